// ----- hdl/ngsi_pkg.sv -----
// shared widths and constants for the nearest greater/smaller index block
// no dependencies
`default_nettype none

package ngsi_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 7;
	localparam int NBR_W       = 8;

	localparam logic [NBR_W-1:0] NONE_POS = '1;

	// pass codes: bit 1 set means forward scan, bit 0 set means smaller search
	localparam logic [1:0] PASS_NEXT_GREATER = 2'd0;
	localparam logic [1:0] PASS_NEXT_SMALLER = 2'd1;
	localparam logic [1:0] PASS_PREV_GREATER = 2'd2;
	localparam logic [1:0] PASS_PREV_SMALLER = 2'd3;

endpackage

`default_nettype wire

// ----- hdl/nearest_greater_smaller_indices.sv -----
// nearest greater/smaller index finder: top level, sequencer and stores
// depends on ngsi_pkg and ngsi_ram
`default_nettype none

// Usage
//   Input: an item (value, last) is taken at a rising edge with start high and
//   busy low. Items are stored in order; the item with last set, or the
//   MAX_LEN-th item, closes the sequence and busy rises.
//   Loading can take one item per cycle.
//   Processing: four monotonic stack passes run over the stored sequence with
//   one shared signed comparator and single-port-read rams. Per pass each
//   element is read (ST_RDCUR, ST_WCUR) and compared (ST_CMP); a stack pop
//   that leaves the stack non-empty reloads the new top (ST_RDIDX, ST_RDTV)
//   before the next compare, and one that empties it compares again directly;
//   every element is popped at most once a pass.
//   Output: one result per position, position 1 first, with result_valid high
//   for one cycle; each is read from the result rams (ST_OUTRD) and then
//   shown (ST_OUT), never back to back; final_res marks the last one.
//   The receiver cannot stall; results are lost if it is not listening.
//   After the final result busy falls in the next cycle.
//   Reset (arst_n low) empties the sequence and returns to loading; stored
//   values are not cleared and are never read before they are written.
module nearest_greater_smaller_indices #(
	parameter int MAX_LEN = ngsi_pkg::MAX_LEN_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [ngsi_pkg::VALUE_W-1:0] value,
	input  wire logic                              last,
	output logic                                   result_valid,
	output logic        [ngsi_pkg::POS_W-1:0]      position,
	output logic signed [ngsi_pkg::NBR_W-1:0]      next_greater_pos,
	output logic signed [ngsi_pkg::NBR_W-1:0]      next_smaller_pos,
	output logic signed [ngsi_pkg::NBR_W-1:0]      prev_greater_pos,
	output logic signed [ngsi_pkg::NBR_W-1:0]      prev_smaller_pos,
	output logic                                   final_res
);

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int VW    = ngsi_pkg::VALUE_W;
	localparam int NW    = ngsi_pkg::NBR_W;
	localparam int PW    = ngsi_pkg::POS_W;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_RDCUR = 3'd1;
	localparam logic [2:0] ST_WCUR  = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_RDIDX = 3'd4;
	localparam logic [2:0] ST_RDTV  = 3'd5;
	localparam logic [2:0] ST_OUTRD = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     j_q;
	logic [CNT_W-1:0]     depth_q;
	logic [1:0]           pass_q;
	logic [IDX_W-1:0]     top_q;
	logic signed [VW-1:0] topv_q;
	logic signed [VW-1:0] cur_q;

	logic                 accept;
	logic                 backward;
	logic                 want_greater;
	logic                 pop;
	logic                 push;
	logic [IDX_W-1:0]     cur_idx;
	logic [CNT_W-1:0]     rev_k;
	logic [NW-1:0]        nbr;

	logic                 val_we;
	logic [IDX_W-1:0]     val_raddr;
	logic [VW-1:0]        val_rdata;
	logic [IDX_W-1:0]     stk_raddr;
	logic [IDX_W-1:0]     stk_rdata;
	logic [CNT_W-1:0]     stk_rd_cnt;
	logic [3:0]           res_we;
	logic [NW-1:0]        res_rdata [4];

	assign busy         = (state_q != ST_LOAD);
	assign accept       = start && !busy;
	assign backward     = !pass_q[1];
	assign want_greater = !pass_q[0];

	assign rev_k   = n_q - CNT_W'(1) - k_q;
	assign cur_idx = backward ? rev_k[IDX_W-1:0] : k_q[IDX_W-1:0];

	// shared comparator: pop when the stack top is strictly on the wrong side
	always_comb begin
		if (depth_q == '0) begin
			pop = 1'b0;
		end else if (want_greater) begin
			pop = (topv_q < cur_q);
		end else begin
			pop = (topv_q > cur_q);
		end
	end

	assign push = (state_q == ST_CMP) && !pop;
	assign nbr  = (depth_q == '0) ? ngsi_pkg::NONE_POS : (NW'(top_q) + NW'(1));

	assign val_we     = accept;
	assign val_raddr  = (state_q == ST_RDIDX) ? stk_rdata : cur_idx;
	// new top after a pop sits two below the current depth
	assign stk_rd_cnt = depth_q - CNT_W'(2);
	assign stk_raddr  = stk_rd_cnt[IDX_W-1:0];

	always_comb begin
		for (int p = 0; p < 4; p++) begin
			res_we[p] = push && (pass_q == 2'(p));
		end
	end

	ngsi_ram #(.WIDTH(VW), .DEPTH(MAX_LEN)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (value),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	ngsi_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_stk_ram (
		.clk   (clk),
		.we    (push),
		.waddr (depth_q[IDX_W-1:0]),
		.wdata (cur_idx),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	for (genvar g = 0; g < 4; g++) begin : g_res
		ngsi_ram #(.WIDTH(NW), .DEPTH(MAX_LEN)) u_res_ram (
			.clk   (clk),
			.we    (res_we[g]),
			.waddr (cur_idx),
			.wdata (nbr),
			.raddr (j_q[IDX_W-1:0]),
			.rdata (res_rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			n_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
			depth_q <= '0;
			pass_q  <= ngsi_pkg::PASS_NEXT_GREATER;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (last || (count_q + CNT_W'(1) == CNT_W'(MAX_LEN))) begin
							n_q     <= count_q + CNT_W'(1);
							count_q <= '0;
							k_q     <= '0;
							depth_q <= '0;
							pass_q  <= ngsi_pkg::PASS_NEXT_GREATER;
							state_q <= ST_RDCUR;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_RDCUR: state_q <= ST_WCUR;
				ST_WCUR:  state_q <= ST_CMP;
				ST_CMP: begin
					if (pop) begin
						depth_q <= depth_q - CNT_W'(1);
						state_q <= (depth_q == CNT_W'(1)) ? ST_CMP : ST_RDIDX;
					end else if (k_q + CNT_W'(1) == n_q) begin
						k_q     <= '0;
						depth_q <= '0;
						if (pass_q == ngsi_pkg::PASS_PREV_SMALLER) begin
							j_q     <= '0;
							state_q <= ST_OUTRD;
						end else begin
							pass_q  <= pass_q + 2'd1;
							state_q <= ST_RDCUR;
						end
					end else begin
						depth_q <= depth_q + CNT_W'(1);
						k_q     <= k_q + CNT_W'(1);
						state_q <= ST_RDCUR;
					end
				end
				ST_RDIDX: state_q <= ST_RDTV;
				ST_RDTV:  state_q <= ST_CMP;
				ST_OUTRD: state_q <= ST_OUT;
				ST_OUT: begin
					if (j_q + CNT_W'(1) == n_q) begin
						state_q <= ST_LOAD;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= ST_OUTRD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// stack top and current value registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_WCUR) begin
			cur_q <= $signed(val_rdata);
		end
		if (push) begin
			top_q  <= cur_idx;
			topv_q <= cur_q;
		end
		if (state_q == ST_RDIDX) begin
			top_q <= stk_rdata;
		end
		if (state_q == ST_RDTV) begin
			topv_q <= $signed(val_rdata);
		end
	end

	assign result_valid     = (state_q == ST_OUT);
	assign position         = PW'(j_q) + PW'(1);
	assign final_res        = (j_q + CNT_W'(1) == n_q);
	assign next_greater_pos = $signed(res_rdata[ngsi_pkg::PASS_NEXT_GREATER]);
	assign next_smaller_pos = $signed(res_rdata[ngsi_pkg::PASS_NEXT_SMALLER]);
	assign prev_greater_pos = $signed(res_rdata[ngsi_pkg::PASS_PREV_GREATER]);
	assign prev_smaller_pos = $signed(res_rdata[ngsi_pkg::PASS_PREV_SMALLER]);

endmodule

`default_nettype wire

// ----- hdl/ngsi_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module ngsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/ngsi_chk.sv -----
// port-level checker for nearest_greater_smaller_indices, with its bind
// depends on ngsi_pkg
`default_nettype none

module ngsi_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              busy,
	input wire logic                              result_valid,
	input wire logic        [ngsi_pkg::POS_W-1:0] position,
	input wire logic signed [ngsi_pkg::NBR_W-1:0] next_greater_pos,
	input wire logic                              final_res
);

	// results only come out while the block is processing
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe while not busy");

	// after the final result the block is ready for a new sequence
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && final_res |=> !busy)
		else $error("still busy after final result");

	// positions come out in order, each one the previous plus one
	a_pos_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !final_res |-> ##2
		(result_valid && position == $past(position, 2) + 7'd1))
		else $error("result positions out of order");

	// a position is never its own next greater neighbor
	a_not_self: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (next_greater_pos != $signed({1'b0, position})))
		else $error("next greater points at itself");

endmodule

bind nearest_greater_smaller_indices ngsi_chk u_ngsi_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.busy             (busy),
	.result_valid     (result_valid),
	.position         (position),
	.next_greater_pos (next_greater_pos),
	.final_res        (final_res)
);

`default_nettype wire
